@@ sv/vchm_pkg.sv @@
package vchm_pkg;

	localparam int unsigned OP_W = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned NUMBER_W = 14;
	localparam int unsigned COUNT_W = 15;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd4;

	localparam logic [31:0] PRIME_X = 32'd92837111;
	localparam logic [31:0] PRIME_Y = 32'd689287499;
	localparam logic [31:0] PRIME_Z = 32'd283923481;

	typedef struct packed {
		logic head_we;
		logic cell_we;
	} vchm_wr_t;

endpackage

@@ sv/voxel_cell_hash_map_core.sv @@
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser op, tdata x y z
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser status, tdata number count
//
// lookup or insert: after accept the hash, then a bucket head read, then a walk along the chain;
// the hash takes four pipeline stages, each chain step one cell memory read
// clear: one bucket head written per cycle
// after reset a pass over every bucket empties the bucket heads, no request taken
// one request in flight; a result waiting in the output register holds back the next
module voxel_cell_hash_map_core #(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned MAX_CELLS = 16384,
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [47:0]                     s_axis_tdata,  // cell_x, cell_y, cell_z
	input  logic [vchm_pkg::OP_W-1:0]       s_axis_tuser,  // op
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // cell_number, cell_count, zero pad
	output logic [vchm_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
	import vchm_pkg::*;

	localparam int unsigned BW = $clog2(HASH_BUCKETS);
	localparam int unsigned CW = $clog2(MAX_CELLS);
	localparam int unsigned LW = $clog2(MAX_CELLS+1);
	localparam int unsigned CB = COORD_BITS;
	localparam int unsigned EW = 3*CB + LW;
	localparam logic [LW-1:0] NO_LINK = LW'(MAX_CELLS);
	localparam logic [BW-1:0] LAST_BUCKET = BW'(HASH_BUCKETS-1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_HASH  = 9'b000000010,
		ST_HEAD  = 9'b000000100,
		ST_CHK   = 9'b000001000,
		ST_CELL  = 9'b000010000,
		ST_DONE  = 9'b000100000,
		ST_INIT  = 9'b001000000,
		ST_CLEAR = 9'b010000000,
		ST_SPARE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [OP_W-1:0] op_q;
	logic signed [CB-1:0] x_q, y_q, z_q;
	logic [LW-1:0] stored_q, head_q, cur_q, steps_q;
	logic [BW-1:0] sweep_q;
	logic [BW-1:0] bucket_q;
	logic hit_q;

	logic m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [NUMBER_W-1:0] number_q;
	logic [COUNT_W-1:0] count_q;

	logic accept;
	logic [31:0] x32, y32, z32;
	logic signed [CB-1:0] in_x, in_y, in_z;
	logic hash_start, hash_done;
	logic [BW-1:0] bucket;

	vchm_wr_t wr;
	logic [BW-1:0] head_waddr;
	logic [LW-1:0] head_rdata, head_wdata;
	logic [EW-1:0] cell_rdata, cell_wdata;

	logic signed [CB-1:0] rd_x, rd_y, rd_z;
	logic [LW-1:0] rd_next;
	logic key_match, walk_go, out_free, can_insert;

	logic [STATUS_W-1:0] res_status;
	logic [LW-1:0] res_number, res_count;
	logic [31:0] number_ext, count_ext;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// wrap or extend each coordinate to the stored width
	assign x32 = 32'(signed'(s_axis_tdata[15:0]));
	assign y32 = 32'(signed'(s_axis_tdata[31:16]));
	assign z32 = 32'(signed'(s_axis_tdata[47:32]));
	assign in_x = x32[CB-1:0];
	assign in_y = y32[CB-1:0];
	assign in_z = z32[CB-1:0];

	assign hash_start = accept && (s_axis_tuser != OP_CLEAR);

	vchm_hash #(
		.HASH_BUCKETS(HASH_BUCKETS),
		.COORD_BITS(COORD_BITS)
	) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(hash_start),
		.x(in_x),
		.y(in_y),
		.z(in_z),
		.done(hash_done),
		.bucket(bucket)
	);

	assign rd_next = cell_rdata[LW-1:0];
	assign rd_z = cell_rdata[LW +: CB];
	assign rd_y = cell_rdata[LW+CB +: CB];
	assign rd_x = cell_rdata[LW+2*CB +: CB];
	assign key_match = (rd_x == x_q) && (rd_y == y_q) && (rd_z == z_q);
	assign walk_go = (cur_q < stored_q) && (steps_q < stored_q);
	assign out_free = !m_valid_q || m_axis_tready;
	assign can_insert = (stored_q < NO_LINK);

	always_comb begin
		res_status = STATUS_NOT_FOUND;
		res_number = '0;
		res_count = stored_q;
		if (op_q == OP_CLEAR) begin
			res_status = STATUS_CLEARED;
			res_count = '0;
		end else if (hit_q) begin
			res_status = STATUS_FOUND;
			res_number = cur_q;
		end else if (op_q == OP_INSERT) begin
			if (can_insert) begin
				res_status = STATUS_INSERTED;
				res_number = stored_q;
				res_count = stored_q + LW'(1);
			end else begin
				res_status = STATUS_FULL;
			end
		end
	end

	assign number_ext = 32'(res_number);
	assign count_ext = 32'(res_count);

	always_comb begin
		wr.head_we = 1'b0;
		wr.cell_we = 1'b0;
		head_waddr = bucket_q;
		head_wdata = stored_q;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			wr.head_we = 1'b1;
			head_waddr = sweep_q;
			head_wdata = NO_LINK;
		end else if (state_q == ST_DONE && out_free && op_q == OP_INSERT && !hit_q
				&& can_insert) begin
			wr.head_we = 1'b1;
			wr.cell_we = 1'b1;
		end
	end

	// new cell is pushed at the chain front
	assign cell_wdata = {x_q, y_q, z_q, head_q};

	vchm_store #(
		.HASH_BUCKETS(HASH_BUCKETS),
		.MAX_CELLS(MAX_CELLS),
		.COORD_BITS(COORD_BITS)
	) u_store (
		.clk(clk),
		.wr(wr),
		.head_raddr(bucket),
		.head_rdata(head_rdata),
		.head_waddr(head_waddr),
		.head_wdata(head_wdata),
		.cell_raddr(cur_q[CW-1:0]),
		.cell_rdata(cell_rdata),
		.cell_waddr(stored_q[CW-1:0]),
		.cell_wdata(cell_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			stored_q <= '0;
			sweep_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == OP_CLEAR) begin
							stored_q <= '0;
							sweep_q <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= walk_go ? ST_CELL : ST_DONE;
				end
				ST_CELL: begin
					state_q <= key_match ? ST_DONE : ST_CHK;
				end
				ST_DONE: begin
					if (out_free) begin
						if (wr.cell_we) begin
							stored_q <= stored_q + LW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					sweep_q <= sweep_q + BW'(1);
					if (sweep_q == LAST_BUCKET) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + BW'(1);
					if (sweep_q == LAST_BUCKET) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_axis_tuser;
			x_q <= in_x;
			y_q <= in_y;
			z_q <= in_z;
			hit_q <= 1'b0;
		end
		// the hash pipeline holds the bucket for one cycle only
		if (state_q == ST_HASH && hash_done) begin
			bucket_q <= bucket;
		end
		if (state_q == ST_HEAD) begin
			head_q <= head_rdata;
			cur_q <= head_rdata;
			steps_q <= '0;
		end
		if (state_q == ST_CELL) begin
			if (key_match) begin
				hit_q <= 1'b1;
			end else begin
				cur_q <= rd_next;
				steps_q <= steps_q + LW'(1);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			status_q <= res_status;
			number_q <= number_ext[NUMBER_W-1:0];
			count_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = status_q;
	assign m_axis_tdata = {3'b000, count_q, number_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= NO_LINK)
		else $error("cell count beyond capacity");

	a_hash_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == ST_HASH))
		else $error("bucket ready outside hash wait");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == OP_CLEAR) |=> (stored_q == '0))
		else $error("clear request left cells stored");

	a_cell_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (cur_q < stored_q))
		else $error("chain walk read an unwritten cell");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second request taken while one is in flight");

endmodule

@@ sv/vchm_hash.sv @@
module vchm_hash #(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [COORD_BITS-1:0]          x,
	input  logic signed [COORD_BITS-1:0]          y,
	input  logic signed [COORD_BITS-1:0]          z,
	output logic                                  done,
	output logic [$clog2(HASH_BUCKETS)-1:0]       bucket
);
	import vchm_pkg::*;

	localparam int unsigned BW = $clog2(HASH_BUCKETS);
	localparam logic [63:0] RECIP_W = (64'd1 << 32) / 64'(HASH_BUCKETS);
	localparam logic [31:0] RECIP = RECIP_W[31:0];
	localparam logic [31:0] DIV = 32'(HASH_BUCKETS);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] px_s1, py_s1, pz_s1;
	logic [31:0] h_s2, q_s2;
	logic [31:0] h_s3, qd_s3;
	logic [BW-1:0] bucket_s4;

	logic [31:0] xw, yw, zw;
	logic [31:0] h_mix;
	logic [63:0] h_recip;
	logic [31:0] r_raw, r_fix;

	assign xw = 32'(x);
	assign yw = 32'(y);
	assign zw = 32'(z);
	assign h_mix = px_s1 ^ py_s1 ^ pz_s1;
	assign h_recip = 64'(h_mix) * 64'(RECIP);
	assign r_raw = h_s3 - qd_s3;
	assign r_fix = (r_raw >= DIV) ? r_raw - DIV : r_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// prime products, then quotient estimate by reciprocal, then remainder
	always_ff @(posedge clk) begin
		px_s1 <= xw * PRIME_X;
		py_s1 <= yw * PRIME_Y;
		pz_s1 <= zw * PRIME_Z;
		h_s2 <= h_mix;
		q_s2 <= h_recip[63:32];
		h_s3 <= h_s2;
		qd_s3 <= q_s2 * DIV;
		bucket_s4 <= r_fix[BW-1:0];
	end

	assign done = v_s4;
	assign bucket = bucket_s4;

endmodule

@@ sv/vchm_store.sv @@
module vchm_store #(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned MAX_CELLS = 16384,
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                                              clk,
	input  vchm_pkg::vchm_wr_t                                wr,
	input  logic [$clog2(HASH_BUCKETS)-1:0]                   head_raddr,
	output logic [$clog2(MAX_CELLS+1)-1:0]                    head_rdata,
	input  logic [$clog2(HASH_BUCKETS)-1:0]                   head_waddr,
	input  logic [$clog2(MAX_CELLS+1)-1:0]                    head_wdata,
	input  logic [$clog2(MAX_CELLS)-1:0]                      cell_raddr,
	output logic [3*COORD_BITS+$clog2(MAX_CELLS+1)-1:0]       cell_rdata,
	input  logic [$clog2(MAX_CELLS)-1:0]                      cell_waddr,
	input  logic [3*COORD_BITS+$clog2(MAX_CELLS+1)-1:0]       cell_wdata
);
	import vchm_pkg::*;

	localparam int unsigned LW = $clog2(MAX_CELLS+1);
	localparam int unsigned EW = 3*COORD_BITS + LW;

	logic [LW-1:0] head_mem [HASH_BUCKETS];
	logic [EW-1:0] cell_mem [MAX_CELLS];

	// chain heads
	always_ff @(posedge clk) begin
		if (wr.head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rdata <= head_mem[head_raddr];
	end

	// cell entries: x, y, z, next link
	always_ff @(posedge clk) begin
		if (wr.cell_we) begin
			cell_mem[cell_waddr] <= cell_wdata;
		end
		cell_rdata <= cell_mem[cell_raddr];
	end

endmodule

@@ tb/vchm_checker.sv @@
`timescale 1ns / 100ps
module vchm_checker #(
	parameter int unsigned HASH_BUCKETS = 4096,
	parameter int unsigned MAX_CELLS = 16384
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [47:0]            s_axis_tdata,
	input  logic [vchm_pkg::OP_W-1:0]     s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [31:0]            m_axis_tdata,
	input  logic [vchm_pkg::STATUS_W-1:0] m_axis_tuser,
	output int                     failures,
	output int                     pending,
	output int                     checked
);
	import vchm_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NUMBER_W-1:0] number;
		logic [COUNT_W-1:0]  count;
	} cell_answer_t;

	int unsigned chain_head [HASH_BUCKETS];
	int unsigned chain_next [MAX_CELLS];
	logic [15:0] stored_x [MAX_CELLS];
	logic [15:0] stored_y [MAX_CELLS];
	logic [15:0] stored_z [MAX_CELLS];
	int unsigned cells_held;

	cell_answer_t answers_due [$];
	int mismatch_tally;
	int answers_seen;

	function automatic void empty_map();
		for (int i = 0; i < HASH_BUCKETS; i++)
			chain_head[i] = MAX_CELLS;
		cells_held = 0;
	endfunction

	function automatic int unsigned hash_bucket(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		logic [31:0] mix;
		mix = ({{16{x[15]}}, x} * PRIME_X) ^ ({{16{y[15]}}, y} * PRIME_Y)
			^ ({{16{z[15]}}, z} * PRIME_Z);
		return mix % HASH_BUCKETS;
	endfunction

	function automatic cell_answer_t answer_request(logic [OP_W-1:0] op, logic [47:0] key);
		cell_answer_t ans;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		int unsigned slot;
		int unsigned node;
		int unsigned steps;
		bit hit;
		ans = '0;
		x = key[15:0];
		y = key[31:16];
		z = key[47:32];
		if (op == OP_CLEAR) begin
			empty_map();
			ans.status = STATUS_CLEARED;
		end else begin
			slot = hash_bucket(x, y, z);
			node = chain_head[slot];
			steps = 0;
			hit = 1'b0;
			while (!hit && node < cells_held && node < MAX_CELLS && steps < cells_held) begin
				if (stored_x[node] == x && stored_y[node] == y && stored_z[node] == z) begin
					hit = 1'b1;
				end else begin
					node = chain_next[node];
					steps++;
				end
			end
			if (hit) begin
				ans.status = STATUS_FOUND;
				ans.number = NUMBER_W'(node);
			end else if (op != OP_INSERT) begin
				ans.status = STATUS_NOT_FOUND;
			end else if (cells_held >= MAX_CELLS) begin
				ans.status = STATUS_FULL;
			end else begin
				stored_x[cells_held] = x;
				stored_y[cells_held] = y;
				stored_z[cells_held] = z;
				chain_next[cells_held] = chain_head[slot];
				chain_head[slot] = cells_held;
				ans.status = STATUS_INSERTED;
				ans.number = NUMBER_W'(cells_held);
				cells_held++;
			end
		end
		ans.count = COUNT_W'(cells_held);
		return ans;
	endfunction

	always @(posedge clk) begin : watch
		cell_answer_t due;
		cell_answer_t seen;
		if (!arst_n) begin
			empty_map();
			answers_due.delete();
			mismatch_tally = 0;
			answers_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.status = m_axis_tuser;
				seen.number = m_axis_tdata[NUMBER_W-1:0];
				seen.count = m_axis_tdata[NUMBER_W +: COUNT_W];
				answers_seen++;
				if (answers_due.size() == 0) begin
					mismatch_tally++;
					if (mismatch_tally <= 10)
						$display("unexpected result at %0t: status %0d number %0d count %0d",
							$realtime, seen.status, seen.number, seen.count);
				end else begin
					due = answers_due.pop_front();
					if (seen.status !== due.status || seen.number !== due.number
							|| seen.count !== due.count) begin
						mismatch_tally++;
						if (mismatch_tally <= 10)
							$display("mismatch at %0t: expected %0d %0d %0d, got %0d %0d %0d",
								$realtime, due.status, due.number, due.count,
								seen.status, seen.number, seen.count);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				answers_due.insert(answers_due.size(),
					answer_request(s_axis_tuser, s_axis_tdata));
		end
		pending <= answers_due.size();
		failures <= mismatch_tally;
		checked <= answers_seen;
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import vchm_pkg::*;

	localparam int unsigned HASH_BUCKETS = 4096;
	localparam int unsigned MAX_CELLS = 16384;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [47:0]         s_axis_tdata;
	logic [OP_W-1:0]     s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [31:0]         m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	int failures;
	int pending;
	int checked;
	bit idling = 1'b1;
	int unsigned requests_sent = 0;
	logic [47:0] key_pool [$];

	voxel_cell_hash_map_core #(
		.HASH_BUCKETS(HASH_BUCKETS),
		.MAX_CELLS(MAX_CELLS),
		.COORD_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	vchm_checker #(
		.HASH_BUCKETS(HASH_BUCKETS),
		.MAX_CELLS(MAX_CELLS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.failures(failures),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#300_000_000;
		$display("FAIL");
		$finish;
	end

	// result side back-pressure
	initial begin : sink
		forever begin
			if (idling && $urandom_range(0, 3) == 0)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	function automatic logic [47:0] cell_key(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [15:0] random_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 8)) - 16'd4;
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [47:0] key);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= key;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
		if (op == OP_INSERT)
			key_pool.insert(key_pool.size(), key);
		else if (op == OP_CLEAR)
			key_pool.delete();
		if (idling && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		int unsigned roll;
		logic [OP_W-1:0] op;
		logic [47:0] key;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			op = OP_CLEAR;
		else if (roll < 6)
			op = OP_SPARE;
		else if (roll < 55)
			op = OP_INSERT;
		else
			op = OP_LOOKUP;
		// half the keys revisit cells already stored
		if (key_pool.size() != 0 && $urandom_range(0, 1) == 1)
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else
			key = {random_coord(), random_coord(), random_coord()};
		send_request(op, key);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= OP_LOOKUP;
		s_axis_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_LOOKUP, cell_key(0, 0, 0));
		send_request(OP_INSERT, cell_key(0, 0, 0));
		send_request(OP_INSERT, cell_key(0, 0, 0));
		send_request(OP_LOOKUP, cell_key(0, 0, 0));
		send_request(OP_INSERT, cell_key(-32768, -32768, -32768));
		send_request(OP_INSERT, cell_key(32767, 32767, 32767));
		send_request(OP_INSERT, cell_key(-1, -1, -1));
		send_request(OP_INSERT, cell_key(32767, -32768, 1));
		// same bucket, chain of two
		send_request(OP_INSERT, cell_key(1, 0, 0));
		send_request(OP_INSERT, cell_key(4097, 0, 0));
		send_request(OP_LOOKUP, cell_key(1, 0, 0));
		send_request(OP_LOOKUP, cell_key(8193, 0, 0));
		send_request(OP_SPARE, cell_key(4097, 0, 0));
		send_request(OP_SPARE, cell_key(2, 2, 2));
		send_request(OP_LOOKUP, cell_key(-32768, -32768, -32768));
		send_request(OP_CLEAR, cell_key(-1, -1, -1));
		send_request(OP_LOOKUP, cell_key(0, 0, 0));
		send_request(OP_INSERT, cell_key(-1, -1, -1));
		wait_drained();

		repeat (300) send_random();
		wait_drained();
		repeat (300) send_random();
		idling = 1'b0;
		repeat (150) send_random();
		wait_drained();
		repeat (20) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d mismatches",
			requests_sent, checked, failures);
		$display("lookups, inserts, clears and the spare op under stalls, with shared buckets");
		if (failures == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
